// ----- src/lfsp_pkg.sv -----
// Package for the slot pool: operation and status codes, control handshake types.
`default_nettype none
package lfsp_pkg;

  localparam int SLOTS_DEF = 1024;

  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_REUSE = 3'd1;
  localparam logic [2:0] OP_FREE  = 3'd2;
  localparam logic [2:0] OP_SUCC  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REUSED   = 2'd2;
  localparam logic [1:0] ST_NOT_LIVE = 2'd3;

  typedef struct packed {
    logic latch;
    logic rd;
    logic exec;
    logic wr2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/lfsp_ctrl.sv -----
// Sequencer for the slot pool: steps each beat through read, update, link fix-up, output.
`default_nettype none
module lfsp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire lfsp_pkg::stat_t stat,
  output lfsp_pkg::cmd_t      cmd
);
  import lfsp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WR2  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.wr2 = 1'b1;
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/lfsp_dp.sv -----
// Datapath for the slot pool: link memories, list registers and the output register.
`default_nettype none
module lfsp_dp #(
  parameter  int SLOTS = lfsp_pkg::SLOTS_DEF,
  localparam int SW    = $clog2(SLOTS + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lfsp_pkg::cmd_t cmd,
  output lfsp_pkg::stat_t     stat,
  input  wire logic [2:0]     in_op,
  input  wire logic [SW-1:0]  in_slot,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic [SW-1:0]       out_slot,
  output logic [1:0]          out_status,
  output logic                out_at_end,
  output logic [SW-1:0]       out_count
);
  import lfsp_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam logic [SW-1:0] END = SW'(SLOTS);

  // Entry: {live flag, next link}
  logic [SW:0]   lnk_mem [SLOTS];
  logic [SW-1:0] prv_mem [SLOTS];

  logic [2:0]    op_r;
  logic [SW-1:0] slot_r;
  logic [SW:0]   lnk_q;
  logic [SW-1:0] prv_q;

  logic [SW-1:0] free_head_r, free_head_nxt;
  logic [SW-1:0] first_r, first_nxt;
  logic [SW-1:0] last_r, last_nxt;
  logic [SW-1:0] used_r, used_nxt;
  logic [SW-1:0] fresh_r, fresh_nxt;   // slots at or above this mark are untouched since clear

  logic          wr2_en_r, wr2_en_nxt;
  logic [AW-1:0] wr2_addr_r, wr2_addr_nxt;
  logic [SW:0]   wr2_data_r, wr2_data_nxt;

  logic [SW-1:0] res_slot_r, res_slot_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          res_end_r, res_end_nxt;

  logic          out_valid_r;
  logic [SW-1:0] out_slot_r, out_count_r;
  logic [1:0]    out_st_r;
  logic          out_end_r;

  logic          lnk_we;
  logic [AW-1:0] lnk_waddr;
  logic [SW:0]   lnk_wdata;
  logic          prv_we;
  logic [AW-1:0] prv_waddr;
  logic [SW-1:0] prv_wdata;
  logic [AW-1:0] lnk_raddr;

  logic          full;
  logic          s_live;
  logic          fresh_take;
  logic [SW-1:0] nxt_q;

  assign lnk_raddr = (op_r == OP_ALLOC || op_r == OP_REUSE) ? free_head_r[AW-1:0]
                                                           : slot_r[AW-1:0];
  assign nxt_q      = lnk_q[SW-1:0];
  assign full       = (used_r >= END) || (free_head_r >= END);
  assign s_live     = (slot_r < fresh_r) && lnk_q[SW];
  assign fresh_take = (free_head_r == fresh_r);

  always_comb begin
    free_head_nxt = free_head_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    used_nxt      = used_r;
    fresh_nxt     = fresh_r;
    wr2_en_nxt    = wr2_en_r;
    wr2_addr_nxt  = wr2_addr_r;
    wr2_data_nxt  = wr2_data_r;
    res_slot_nxt  = res_slot_r;
    res_st_nxt    = res_st_r;
    res_end_nxt   = res_end_r;
    lnk_we        = 1'b0;
    lnk_waddr     = '0;
    lnk_wdata     = '0;
    prv_we        = 1'b0;
    prv_waddr     = '0;
    prv_wdata     = '0;

    if (cmd.exec) begin
      wr2_en_nxt   = 1'b0;
      res_slot_nxt = END;
      res_st_nxt   = ST_OK;
      res_end_nxt  = 1'b0;
      case (op_r)
        OP_ALLOC, OP_REUSE: begin
          if (full) begin
            if (op_r == OP_REUSE) begin
              res_slot_nxt = END - SW'(1);
              res_st_nxt   = ST_REUSED;
            end else begin
              res_st_nxt = ST_FULL;
            end
          end else begin
            // Pop the free head; an untouched slot links to the one above it
            if (fresh_take) begin
              free_head_nxt = free_head_r + SW'(1);
              fresh_nxt     = fresh_r + SW'(1);
            end else begin
              free_head_nxt = nxt_q;
            end
            lnk_we    = 1'b1;
            lnk_waddr = free_head_r[AW-1:0];
            lnk_wdata = {1'b1, END};
            prv_we    = 1'b1;
            prv_waddr = free_head_r[AW-1:0];
            prv_wdata = last_r;
            if (last_r == END) begin
              first_nxt = free_head_r;
            end else begin
              wr2_en_nxt   = 1'b1;
              wr2_addr_nxt = last_r[AW-1:0];
              wr2_data_nxt = {1'b1, free_head_r};
            end
            last_nxt     = free_head_r;
            used_nxt     = used_r + SW'(1);
            res_slot_nxt = free_head_r;
          end
        end
        OP_FREE: begin
          if (!s_live) begin
            res_st_nxt = ST_NOT_LIVE;
          end else begin
            if (prv_q != END) begin
              wr2_en_nxt   = 1'b1;
              wr2_addr_nxt = prv_q[AW-1:0];
              wr2_data_nxt = {1'b1, nxt_q};
            end else begin
              first_nxt = nxt_q;
            end
            if (nxt_q != END) begin
              prv_we    = 1'b1;
              prv_waddr = nxt_q[AW-1:0];
              prv_wdata = prv_q;
            end else begin
              last_nxt = prv_q;
            end
            lnk_we        = 1'b1;
            lnk_waddr     = slot_r[AW-1:0];
            lnk_wdata     = {1'b0, free_head_r};
            free_head_nxt = slot_r;
            if (used_r != '0) begin
              used_nxt = used_r - SW'(1);
            end
            res_slot_nxt = nxt_q;
            res_end_nxt  = (nxt_q == END);
          end
        end
        OP_SUCC: begin
          if (slot_r == END) begin
            res_slot_nxt = first_r;
            res_end_nxt  = (first_r == END);
          end else if (s_live) begin
            res_slot_nxt = nxt_q;
            res_end_nxt  = (nxt_q == END);
          end else begin
            res_st_nxt = ST_NOT_LIVE;
          end
        end
        OP_CLEAR: begin
          // Resetting the fill mark makes every slot read as unlinked and free
          free_head_nxt = '0;
          fresh_nxt     = '0;
          first_nxt     = END;
          last_nxt      = END;
          used_nxt      = '0;
        end
        default: ;
      endcase
    end

    if (cmd.wr2 && wr2_en_r) begin
      lnk_we    = 1'b1;
      lnk_waddr = wr2_addr_r;
      lnk_wdata = wr2_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      lnk_q <= lnk_mem[lnk_raddr];
      prv_q <= prv_mem[slot_r[AW-1:0]];
    end
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    if (prv_we) begin
      prv_mem[prv_waddr] <= prv_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      slot_r <= in_slot;
    end
    wr2_addr_r <= wr2_addr_nxt;
    wr2_data_r <= wr2_data_nxt;
    res_slot_r <= res_slot_nxt;
    res_st_r   <= res_st_nxt;
    res_end_r  <= res_end_nxt;
    if (cmd.load_out) begin
      out_slot_r  <= res_slot_r;
      out_st_r    <= res_st_r;
      out_end_r   <= res_end_r;
      out_count_r <= used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      first_r     <= END;
      last_r      <= END;
      used_r      <= '0;
      fresh_r     <= '0;
      wr2_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      free_head_r <= free_head_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      used_r      <= used_nxt;
      fresh_r     <= fresh_nxt;
      wr2_en_r    <= wr2_en_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_status    = out_st_r;
  assign out_at_end    = out_end_r;
  assign out_count     = out_count_r;

endmodule
`default_nettype wire

// ----- src/linked_free_list_slot_pool.sv -----
// Top level of the slot pool: free list plus doubly linked live list in allocation order.
// A result beat is loaded into the output register in the link fix-up step, or when a
//   stalled output frees. Commands go one at a time through accept, read, update and link
//   fix-up (a separate step, as the next-link memory has a single write port); so does clear.
// A waiting result beat does not block the next command; a stalled output holds the sequencer.
// Reset (rst_n low, synchronous): empty live list, free chain 0..SLOTS-1, no clearing pass.
`default_nettype none
module linked_free_list_slot_pool #(
  parameter  int SLOTS  = lfsp_pkg::SLOTS_DEF,
  localparam int SW     = $clog2(SLOTS + 1),
  localparam int IN_DW  = ((SW + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * SW + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // [SW-1:0] slot, rest zero
  input  wire logic [2:0]        in_tuser,   // [2:0] operation
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // [SW-1:0] result_slot, [2*SW-1:SW] live_count
  output logic [1:0]             out_tuser,  // [1:0] status
  output logic                   out_tlast   // at_end
);
  import lfsp_pkg::*;

  cmd_t          cmd;
  stat_t         stat;
  logic [SW-1:0] res_slot;
  logic [SW-1:0] live_count;

  // Sequencer: one command beat at a time
  lfsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Link memories, list pointers, fill mark and output register
  lfsp_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (in_tuser),
    .in_slot    (in_tdata[SW-1:0]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_slot   (res_slot),
    .out_status (out_tuser),
    .out_at_end (out_tlast),
    .out_count  (live_count)
  );

  // Pack result fields, lowest field first, zero fill to whole bytes
  assign out_tdata = OUT_DW'({live_count, res_slot});

endmodule
`default_nettype wire
